>>> rtl/ordbk_pkg.sv
// Package for the order book matcher: default sizes, the sequencer state type,
// command and status codes. No dependencies.
package ordbk_pkg;

  localparam int MAX_ORDERS_DEF = 32;
  localparam int PRICE_BITS_DEF = 20;
  localparam int QTY_BITS_DEF   = 24;
  localparam int ID_BITS        = 32;
  localparam int ARR_BITS       = 32;
  localparam int BOOKQ_BITS     = 30;
  localparam logic [BOOKQ_BITS-1:0] BOOKQ_MAX = '1;

  typedef enum logic [1:0] {
    CMD_LIMIT  = 2'd0,
    CMD_MARKET = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_BAD    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_EXEC      = 4'd0,
    ST_ACCEPTED  = 4'd1,
    ST_PARTIAL   = 4'd2,
    ST_FILLED    = 4'd3,
    ST_CANCELLED = 4'd4,
    ST_ZERO_QTY  = 4'd5,
    ST_DUPLICATE = 4'd6,
    ST_NOT_FOUND = 4'd7,
    ST_FULL      = 4'd8,
    ST_BAD_CMD   = 4'd9
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_FIND_CHK,
    S_CANCEL,
    S_MATCH,
    S_MATCH_CHK,
    S_EXEC,
    S_POST,
    S_FREE,
    S_INSERT,
    S_TOB,
    S_FINAL
  } state_t;

endpackage

>>> rtl/ordbk_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ordbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/limit_order_book_matcher_core.sv
// Top level of the price-time priority order book matcher.
// Uses ordbk_pkg and one ordbk_ram instance for the resting order table.
//
// Usage: the input channel (in_valid/in_ready) takes one event: limit, market
// or cancel. The result channel (out_valid/out_ready) returns one execution
// item per fill, then one final item with out_last high that carries the
// status, filled and remaining quantity and the top of book after the event.
// Resting orders live in a table of MAX_ORDERS slots. A small sequencer walks
// the table one slot per cycle through the single read port of the table RAM,
// and that walk sets the timing. A resting limit order takes an id pass, one
// matching pass per fill plus one more, a free slot pass and a top of book
// pass. A market order without fills or a cancel takes two passes; a bad
// command or a zero quantity takes only the top of book pass.
// The block takes no new item until the final item of the current one is in
// the output register. An output register holds each result item; when the
// receiver stalls the sequencer waits before loading the next one, and a new
// item is taken while the final item still waits. Reset empties the table and
// clears the arrival counter.
module limit_order_book_matcher_core #(
  parameter int MAX_ORDERS = ordbk_pkg::MAX_ORDERS_DEF,
  parameter int PRICE_BITS = ordbk_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = ordbk_pkg::QTY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic                              in_side_is_buy,
  input  logic [ordbk_pkg::ID_BITS-1:0]     in_order_id,
  input  logic [PRICE_BITS-1:0]             in_limit_price,
  input  logic [QTY_BITS-1:0]               in_quantity,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_last,
  output logic [3:0]                        out_status,
  output logic [ordbk_pkg::ID_BITS-1:0]     out_resting_id,
  output logic [PRICE_BITS-1:0]             out_trade_price,
  output logic [QTY_BITS-1:0]               out_trade_qty,
  output logic [QTY_BITS-1:0]               out_filled_qty,
  output logic [QTY_BITS-1:0]               out_remaining_qty,
  output logic [PRICE_BITS-1:0]             out_best_bid,
  output logic [ordbk_pkg::BOOKQ_BITS-1:0]  out_best_bid_qty,
  output logic [PRICE_BITS-1:0]             out_best_ask,
  output logic [ordbk_pkg::BOOKQ_BITS-1:0]  out_best_ask_qty
);

  import ordbk_pkg::*;

  localparam int IW     = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int W      = 1 + ID_BITS + PRICE_BITS + QTY_BITS + ARR_BITS;
  localparam int SW     = QTY_BITS + $clog2(MAX_ORDERS + 1);
  localparam int Q_LO   = ARR_BITS;
  localparam int P_LO   = ARR_BITS + QTY_BITS;
  localparam int ID_LO  = ARR_BITS + QTY_BITS + PRICE_BITS;
  localparam logic [IW-1:0] LAST = IW'(MAX_ORDERS - 1);

  state_t state_r, state_nxt;

  logic [1:0]            cmd_r;
  logic                  buy_r;
  logic [ID_BITS-1:0]    id_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic [QTY_BITS-1:0]   rem_r;
  logic [QTY_BITS-1:0]   filled_r;
  logic [3:0]            status_r;

  logic                  found_v_r;
  logic [IW-1:0]         found_idx_r;
  logic [W-1:0]          found_word_r;
  logic                  best_v_r;
  logic [IW-1:0]         best_idx_r;
  logic [W-1:0]          best_word_r;
  logic [ARR_BITS-1:0]   best_age_r;
  logic                  free_v_r;
  logic [IW-1:0]         free_idx_r;
  logic                  bid_v_r, ask_v_r;
  logic [PRICE_BITS-1:0] bid_p_r, ask_p_r;
  logic [SW-1:0]         bid_sum_r, ask_sum_r;

  logic [MAX_ORDERS-1:0] slot_valid_r;
  logic [ARR_BITS-1:0]   arrival_r;

  logic [IW-1:0]         scan_cnt_r;
  logic                  scan_run_r;
  logic                  proc_v_r;
  logic [IW-1:0]         proc_idx_r;

  logic                  out_valid_r;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [W-1:0]          ram_wdata;
  logic [W-1:0]          ram_rdata;

  ordbk_ram #(
    .WIDTH (W),
    .DEPTH (MAX_ORDERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt_r),
    .rdata (ram_rdata)
  );

  logic                  rd_buy;
  logic [ID_BITS-1:0]    rd_id;
  logic [PRICE_BITS-1:0] rd_price;
  logic [QTY_BITS-1:0]   rd_qty;
  logic [ARR_BITS-1:0]   rd_arr;
  logic [ARR_BITS-1:0]   cand_age;
  logic                  cur_v;
  logic                  scan_done;
  logic                  in_fire;
  logic                  out_free;
  logic                  cand_better;
  logic [PRICE_BITS-1:0] lead_px;
  logic [QTY_BITS-1:0]   best_qty;
  logic [QTY_BITS-1:0]   found_qty;
  logic [QTY_BITS-1:0]   trade_q;
  logic [QTY_BITS-1:0]   cancel_q;
  logic [QTY_BITS-1:0]   cancel_left;
  logic                  price_fail;
  logic                  scan_start;
  logic                  load_exec;
  logic                  load_final;
  logic [63:0]           bid_sum64, ask_sum64;

  assign rd_buy   = ram_rdata[W-1];
  assign rd_id    = ram_rdata[ID_LO +: ID_BITS];
  assign rd_price = ram_rdata[P_LO +: PRICE_BITS];
  assign rd_qty   = ram_rdata[Q_LO +: QTY_BITS];
  assign rd_arr   = ram_rdata[ARR_BITS-1:0];
  assign cand_age = arrival_r - rd_arr;

  assign cur_v     = proc_v_r && slot_valid_r[proc_idx_r];
  assign scan_done = proc_v_r && (proc_idx_r == LAST);
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign lead_px    = best_word_r[P_LO +: PRICE_BITS];
  assign best_qty   = best_word_r[Q_LO +: QTY_BITS];
  assign found_qty  = found_word_r[Q_LO +: QTY_BITS];
  assign trade_q    = (rem_r < best_qty) ? rem_r : best_qty;
  assign cancel_q   = (qty_r == '0 || qty_r >= found_qty) ? found_qty : qty_r;
  assign cancel_left = found_qty - cancel_q;
  assign price_fail = (cmd_r == CMD_LIMIT) &&
                      (buy_r ? (price_r < lead_px) : (price_r > lead_px));

  always_comb begin
    if (!best_v_r) begin
      cand_better = 1'b1;
    end else if (rd_price != lead_px) begin
      cand_better = rd_buy ? (rd_price > lead_px) : (rd_price < lead_px);
    end else begin
      cand_better = cand_age > best_age_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_command == CMD_BAD) begin
            state_nxt = S_TOB;
          end else if (in_command == CMD_CANCEL) begin
            state_nxt = S_FIND;
          end else if (in_quantity == '0) begin
            state_nxt = S_TOB;
          end else if (in_command == CMD_LIMIT) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_MATCH;
          end
        end
      end
      S_FIND: begin
        if (scan_done) begin
          state_nxt = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (cmd_r == CMD_CANCEL) begin
          state_nxt = found_v_r ? S_CANCEL : S_TOB;
        end else begin
          state_nxt = found_v_r ? S_TOB : S_MATCH;
        end
      end
      S_CANCEL: state_nxt = S_TOB;
      S_MATCH: begin
        if (scan_done) begin
          state_nxt = S_MATCH_CHK;
        end
      end
      S_MATCH_CHK: begin
        state_nxt = (!best_v_r || price_fail) ? S_POST : S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = (rem_r > trade_q) ? S_MATCH : S_POST;
        end
      end
      S_POST: begin
        state_nxt = (cmd_r == CMD_LIMIT && rem_r != '0) ? S_FREE : S_TOB;
      end
      S_FREE: begin
        if (scan_done) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: state_nxt = S_TOB;
      S_TOB: begin
        if (scan_done) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    scan_start = 1'b0;
    if (state_nxt != state_r) begin
      scan_start = (state_nxt == S_FIND) || (state_nxt == S_MATCH) ||
                   (state_nxt == S_FREE) || (state_nxt == S_TOB);
    end
    load_exec  = (state_r == S_EXEC) && out_free;
    load_final = (state_r == S_FINAL) && out_free;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    case (state_r)
      S_CANCEL: begin
        ram_we    = (cancel_left != '0);
        ram_waddr = found_idx_r;
        ram_wdata = found_word_r;
        ram_wdata[Q_LO +: QTY_BITS] = cancel_left;
      end
      S_EXEC: begin
        ram_we    = out_free && (best_qty != trade_q);
        ram_waddr = best_idx_r;
        ram_wdata = best_word_r;
        ram_wdata[Q_LO +: QTY_BITS] = best_qty - trade_q;
      end
      S_INSERT: begin
        ram_we    = free_v_r;
        ram_waddr = free_idx_r;
        ram_wdata = {buy_r, id_r, price_r, rem_r, arrival_r};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_run_r <= 1'b0;
      proc_v_r   <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (scan_start) begin
        scan_cnt_r <= '0;
        scan_run_r <= 1'b1;
        proc_v_r   <= 1'b0;
      end else if (scan_run_r) begin
        proc_v_r   <= 1'b1;
        proc_idx_r <= scan_cnt_r;
        if (scan_cnt_r == LAST) begin
          scan_run_r <= 1'b0;
        end else begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
      end else begin
        proc_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      arrival_r    <= '0;
    end else begin
      if (state_r == S_CANCEL && cancel_left == '0) begin
        slot_valid_r[found_idx_r] <= 1'b0;
      end
      if (load_exec && best_qty == trade_q) begin
        slot_valid_r[best_idx_r] <= 1'b0;
      end
      if (state_r == S_INSERT && free_v_r) begin
        slot_valid_r[free_idx_r] <= 1'b1;
        arrival_r <= arrival_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_command;
      buy_r    <= in_side_is_buy;
      id_r     <= in_order_id;
      price_r  <= in_limit_price;
      qty_r    <= in_quantity;
      filled_r <= '0;
      rem_r    <= (in_command == CMD_MARKET) ? in_quantity : '0;
      status_r <= (in_command == CMD_BAD) ? ST_BAD_CMD : ST_ZERO_QTY;
    end
    case (state_r)
      S_FIND_CHK: begin
        if (cmd_r == CMD_CANCEL) begin
          status_r <= ST_NOT_FOUND;
        end else if (found_v_r) begin
          status_r <= ST_DUPLICATE;
        end else begin
          rem_r <= qty_r;
        end
      end
      S_CANCEL: begin
        status_r <= ST_CANCELLED;
        rem_r    <= cancel_left;
      end
      S_EXEC: begin
        if (out_free) begin
          rem_r    <= rem_r - trade_q;
          filled_r <= filled_r + trade_q;
        end
      end
      S_POST: begin
        if (filled_r != '0 && rem_r != '0) begin
          status_r <= ST_PARTIAL;
        end else if (rem_r == '0) begin
          status_r <= ST_FILLED;
        end else begin
          status_r <= ST_ACCEPTED;
        end
      end
      S_INSERT: begin
        if (!free_v_r) begin
          status_r <= ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      found_v_r <= 1'b0;
      best_v_r  <= 1'b0;
      free_v_r  <= 1'b0;
      bid_v_r   <= 1'b0;
      ask_v_r   <= 1'b0;
      bid_p_r   <= '0;
      ask_p_r   <= '0;
      bid_sum_r <= '0;
      ask_sum_r <= '0;
    end else if (proc_v_r) begin
      case (state_r)
        S_FIND: begin
          if (cur_v && rd_id == id_r) begin
            found_v_r    <= 1'b1;
            found_idx_r  <= proc_idx_r;
            found_word_r <= ram_rdata;
          end
        end
        S_MATCH: begin
          if (cur_v && rd_buy != buy_r && cand_better) begin
            best_v_r    <= 1'b1;
            best_idx_r  <= proc_idx_r;
            best_word_r <= ram_rdata;
            best_age_r  <= cand_age;
          end
        end
        S_FREE: begin
          if (!slot_valid_r[proc_idx_r] && !free_v_r) begin
            free_v_r   <= 1'b1;
            free_idx_r <= proc_idx_r;
          end
        end
        S_TOB: begin
          if (cur_v && rd_buy) begin
            if (!bid_v_r || rd_price > bid_p_r) begin
              bid_v_r   <= 1'b1;
              bid_p_r   <= rd_price;
              bid_sum_r <= SW'(rd_qty);
            end else if (rd_price == bid_p_r) begin
              bid_sum_r <= bid_sum_r + SW'(rd_qty);
            end
          end
          if (cur_v && !rd_buy) begin
            if (!ask_v_r || rd_price < ask_p_r) begin
              ask_v_r   <= 1'b1;
              ask_p_r   <= rd_price;
              ask_sum_r <= SW'(rd_qty);
            end else if (rd_price == ask_p_r) begin
              ask_sum_r <= ask_sum_r + SW'(rd_qty);
            end
          end
        end
        default: found_v_r <= found_v_r;
      endcase
    end
  end

  assign bid_sum64 = 64'(bid_sum_r);
  assign ask_sum64 = 64'(ask_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_exec || load_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_exec) begin
      out_last          <= 1'b0;
      out_status        <= ST_EXEC;
      out_resting_id    <= best_word_r[ID_LO +: ID_BITS];
      out_trade_price   <= lead_px;
      out_trade_qty     <= trade_q;
      out_filled_qty    <= '0;
      out_remaining_qty <= '0;
      out_best_bid      <= '0;
      out_best_bid_qty  <= '0;
      out_best_ask      <= '0;
      out_best_ask_qty  <= '0;
    end else if (load_final) begin
      out_last          <= 1'b1;
      out_status        <= status_r;
      out_resting_id    <= '0;
      out_trade_price   <= '0;
      out_trade_qty     <= '0;
      out_filled_qty    <= filled_r;
      out_remaining_qty <= rem_r;
      out_best_bid      <= bid_p_r;
      out_best_bid_qty  <= (bid_sum64 > 64'(BOOKQ_MAX)) ? BOOKQ_MAX
                                                          : bid_sum64[BOOKQ_BITS-1:0];
      out_best_ask      <= ask_p_r;
      out_best_ask_qty  <= (ask_sum64 > 64'(BOOKQ_MAX)) ? BOOKQ_MAX
                                                          : ask_sum64[BOOKQ_BITS-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/ordbk_checker.sv
// Port-level checks for the order book matcher, bound to the top level.
// Uses ordbk_pkg for the status codes.
module ordbk_checker #(
  parameter int PRICE_BITS = ordbk_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = ordbk_pkg::QTY_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_last,
  input logic [3:0]                    out_status,
  input logic [ordbk_pkg::ID_BITS-1:0] out_resting_id,
  input logic [QTY_BITS-1:0]           out_trade_qty,
  input logic [PRICE_BITS-1:0]         out_trade_price
);

  import ordbk_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input taken while an item is in progress.");

  a_exec_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_EXEC && out_trade_qty != '0)
    else $error("Execution item with wrong status or zero quantity.");

  a_final_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      out_status != ST_EXEC && out_trade_qty == '0 && out_resting_id == '0 &&
      out_trade_price == '0)
    else $error("Final item carries execution fields.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_last))
    else $error("Result item changed while stalled.");

endmodule

bind limit_order_book_matcher_core ordbk_checker #(
  .PRICE_BITS (PRICE_BITS),
  .QTY_BITS   (QTY_BITS)
) u_ordbk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_last        (out_last),
  .out_status      (out_status),
  .out_resting_id  (out_resting_id),
  .out_trade_qty   (out_trade_qty),
  .out_trade_price (out_trade_price)
);
